>>> src/fhcr_pkg.sv
// Shared types and constants for the fragment header check and reassembly block.
// No dependencies; imported by every module of the block but fhcr_queue.
package fhcr_pkg;

    localparam int unsigned HEADER_BYTES_DEF      = 64;
    localparam int unsigned MAX_PACKET_BYTES_DEF  = 65536;
    localparam int unsigned MAX_CHUNK_BYTES_DEF   = 65472;
    localparam int unsigned MAX_MESSAGE_BYTES_DEF = 4194304;
    localparam int unsigned QUEUE_DEPTH_DEF       = 2;

    localparam int unsigned FIELD_W  = 32;
    localparam int unsigned OFFSET_W = 23;
    localparam int unsigned KIND_W   = 3;

    localparam logic [FIELD_W-1:0] MAX_SINGLE_RESET = 32'd65472;

    typedef enum logic [KIND_W-1:0] {
        KIND_INVALID  = 3'd0,
        KIND_SINGLE   = 3'd1,
        KIND_NEW      = 3'd2,
        KIND_CONTINUE = 3'd3,
        KIND_END      = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               off_zero;
        logic               sum_eq;
        logic [FIELD_W-1:0] session_id;
        logic [FIELD_W-1:0] message_size;
        logic [FIELD_W-1:0] chunk_offset;
        logic [FIELD_W-1:0] chunk_end;
    } hdr_item_t;

    typedef struct packed {
        kind_t               kind;
        logic                accepted;
        logic [OFFSET_W-1:0] write_offset;
        logic                message_done;
        logic                dropped_partial;
        logic                buffer_started;
    } result_t;

endpackage

>>> src/fhcr_queue.sv
// Small register queue that parts two stages of the block.
// Depends on nothing but its word type parameter.
module fhcr_queue #(
    parameter type         word_t = logic,
    parameter int unsigned DEPTH  = 2
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  word_t wdata,
    input  logic  pop,
    output logic  empty,
    output word_t rdata
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    word_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> src/fhcr_front.sv
// Front stage: size limit checks and packet classification, no state.
// Depends on fhcr_pkg.
module fhcr_front #(
    parameter int unsigned HEADER_BYTES      = fhcr_pkg::HEADER_BYTES_DEF,
    parameter int unsigned MAX_PACKET_BYTES  = fhcr_pkg::MAX_PACKET_BYTES_DEF,
    parameter int unsigned MAX_CHUNK_BYTES   = fhcr_pkg::MAX_CHUNK_BYTES_DEF,
    parameter int unsigned MAX_MESSAGE_BYTES = fhcr_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic [fhcr_pkg::FIELD_W-1:0] session_id,
    input  logic [fhcr_pkg::FIELD_W-1:0] message_size,
    input  logic [fhcr_pkg::FIELD_W-1:0] chunk_offset,
    input  logic [fhcr_pkg::FIELD_W-1:0] chunk_size,
    input  logic [fhcr_pkg::FIELD_W-1:0] packet_length,
    input  logic [fhcr_pkg::FIELD_W-1:0] max_single_message,
    output fhcr_pkg::hdr_item_t          item
);

    import fhcr_pkg::*;

    localparam logic [FIELD_W-1:0] HDR_LIM = FIELD_W'(HEADER_BYTES);
    localparam logic [FIELD_W-1:0] PKT_LIM = FIELD_W'(MAX_PACKET_BYTES);
    localparam logic [FIELD_W-1:0] CHK_LIM = FIELD_W'(MAX_CHUNK_BYTES);
    localparam logic [FIELD_W-1:0] MSG_LIM = FIELD_W'(MAX_MESSAGE_BYTES);

    logic [FIELD_W:0] len_sum;
    logic [FIELD_W:0] end_sum;
    logic             hdr_ok;
    logic             off_zero;
    logic             sum_eq;

    assign len_sum  = {1'b0, chunk_size} + {1'b0, HDR_LIM};
    assign end_sum  = {1'b0, chunk_offset} + {1'b0, chunk_size};
    assign off_zero = (chunk_offset == '0);
    assign sum_eq   = (end_sum == {1'b0, message_size});

    assign hdr_ok = (packet_length >= HDR_LIM) && (packet_length <= PKT_LIM)
                 && (chunk_size <= CHK_LIM)
                 && (len_sum == {1'b0, packet_length})
                 && (message_size <= MSG_LIM)
                 && (chunk_offset <= message_size) && (chunk_size <= message_size)
                 && (end_sum <= {1'b0, message_size});

    always_comb
    begin
        item.off_zero     = off_zero;
        item.sum_eq       = sum_eq;
        item.session_id   = session_id;
        item.message_size = message_size;
        item.chunk_offset = chunk_offset;
        item.chunk_end    = end_sum[FIELD_W-1:0];
        if (!hdr_ok)
        begin
            item.kind = KIND_INVALID;
        end
        else if (message_size <= max_single_message)
        begin
            item.kind = KIND_SINGLE;
        end
        else if (off_zero)
        begin
            item.kind = KIND_NEW;
        end
        else if (sum_eq)
        begin
            item.kind = KIND_END;
        end
        else
        begin
            item.kind = KIND_CONTINUE;
        end
    end

endmodule

>>> src/fhcr_back.sv
// Back stage: session buffer state, acceptance and completion.
// Depends on fhcr_pkg.
module fhcr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  fhcr_pkg::hdr_item_t item,
    input  logic                advance,
    output fhcr_pkg::result_t   result
);

    import fhcr_pkg::*;

    logic               partial_valid_reg, partial_valid_next;
    logic [FIELD_W-1:0] held_session_reg, held_session_next;
    logic [FIELD_W-1:0] held_total_reg, held_total_next;
    logic [FIELD_W-1:0] received_reg, received_next;

    logic mismatch;
    logic pv_eff;
    logic acc;

    assign mismatch = (held_session_reg != item.session_id);
    assign pv_eff   = partial_valid_reg && !mismatch;

    always_comb
    begin
        partial_valid_next = partial_valid_reg;
        held_session_next  = held_session_reg;
        held_total_next    = held_total_reg;
        received_next      = received_reg;
        acc                = 1'b0;

        result.kind            = item.kind;
        result.accepted        = 1'b0;
        result.write_offset    = '0;
        result.message_done    = 1'b0;
        result.dropped_partial = 1'b0;
        result.buffer_started  = 1'b0;

        case (item.kind)
            KIND_INVALID:
            begin
            end
            KIND_SINGLE:
            begin
                result.accepted     = item.off_zero;
                result.message_done = item.off_zero && item.sum_eq;
            end
            KIND_NEW, KIND_CONTINUE, KIND_END:
            begin
                result.dropped_partial = mismatch && partial_valid_reg;
                if (!pv_eff)
                begin
                    acc                   = item.off_zero;
                    result.buffer_started = item.off_zero;
                end
                else
                begin
                    acc = (held_total_reg == item.message_size)
                       && (received_reg == item.chunk_offset);
                end
                result.accepted = acc;
                if (acc)
                begin
                    result.write_offset = item.chunk_offset[OFFSET_W-1:0];
                    result.message_done = item.sum_eq;
                end

                if (acc && item.sum_eq)
                begin
                    partial_valid_next = 1'b0;
                    held_session_next  = '0;
                    held_total_next    = '0;
                    received_next      = '0;
                end
                else if (acc && !pv_eff)
                begin
                    partial_valid_next = 1'b1;
                    held_session_next  = item.session_id;
                    held_total_next    = item.message_size;
                    received_next      = item.chunk_end;
                end
                else if (acc)
                begin
                    received_next = item.chunk_end;
                end
                else if (mismatch)
                begin
                    partial_valid_next = 1'b0;
                    held_session_next  = '0;
                    held_total_next    = '0;
                    received_next      = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_valid_reg <= 1'b0;
            held_session_reg  <= '0;
            held_total_reg    <= '0;
            received_reg      <= '0;
        end
        else if (item_valid && advance)
        begin
            partial_valid_reg <= partial_valid_next;
            held_session_reg  <= held_session_next;
            held_total_reg    <= held_total_next;
            received_reg      <= received_next;
        end
    end

endmodule

>>> src/fragment_header_check_reassembly.sv
// Top level of the fragment header check and reassembly block.
// Depends on fhcr_pkg, fhcr_front, fhcr_queue and fhcr_back.
//
// Usage:
//   Input side is a queue write port: present a header on session_id,
//   message_size, chunk_offset, chunk_size and packet_length, raise push;
//   the word is taken at a clock edge where push is high and full is low.
//   Result side is a queue read port: while empty is low the oldest result
//   stands on packet_kind, accepted, write_offset, message_done,
//   dropped_partial and buffer_started; pop takes it.
//   The cfg channel writes max_single_message; cfg_ready is always high.
//   Write it only while no header is in flight.
//   Path: front stage, header queue, back stage, result queue; a result is
//   visible once it is registered in the result queue, and pop can take it there.
//   Throughput: one header per cycle while the result queue is not full,
//   set by the session state update in the back stage.
//   Reset clears the buffered session, both queues and sets
//   max_single_message to 65472.
//   If pop stays low the result queue fills, the back stage holds, the
//   header queue fills and full rises; nothing is lost.
module fragment_header_check_reassembly #(
    parameter int unsigned HEADER_BYTES      = fhcr_pkg::HEADER_BYTES_DEF,
    parameter int unsigned MAX_PACKET_BYTES  = fhcr_pkg::MAX_PACKET_BYTES_DEF,
    parameter int unsigned MAX_CHUNK_BYTES   = fhcr_pkg::MAX_CHUNK_BYTES_DEF,
    parameter int unsigned MAX_MESSAGE_BYTES = fhcr_pkg::MAX_MESSAGE_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH       = fhcr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [fhcr_pkg::FIELD_W-1:0]  session_id,
    input  logic [fhcr_pkg::FIELD_W-1:0]  message_size,
    input  logic [fhcr_pkg::FIELD_W-1:0]  chunk_offset,
    input  logic [fhcr_pkg::FIELD_W-1:0]  chunk_size,
    input  logic [fhcr_pkg::FIELD_W-1:0]  packet_length,
    output logic                          empty,
    input  logic                          pop,
    output logic [fhcr_pkg::KIND_W-1:0]   packet_kind,
    output logic                          accepted,
    output logic [fhcr_pkg::OFFSET_W-1:0] write_offset,
    output logic                          message_done,
    output logic                          dropped_partial,
    output logic                          buffer_started,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fhcr_pkg::FIELD_W-1:0]  cfg_data
);

    import fhcr_pkg::*;

    logic [FIELD_W-1:0] max_single_reg;
    hdr_item_t          front_item;
    hdr_item_t          mid_item;
    logic               mid_empty;
    logic               out_full;
    result_t            back_result;
    result_t            out_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_single_reg <= MAX_SINGLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_single_reg <= cfg_data;
        end
    end

    fhcr_front #(
        .HEADER_BYTES      (HEADER_BYTES),
        .MAX_PACKET_BYTES  (MAX_PACKET_BYTES),
        .MAX_CHUNK_BYTES   (MAX_CHUNK_BYTES),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_front (
        .session_id         (session_id),
        .message_size       (message_size),
        .chunk_offset       (chunk_offset),
        .chunk_size         (chunk_size),
        .packet_length      (packet_length),
        .max_single_message (max_single_reg),
        .item               (front_item)
    );

    fhcr_queue #(
        .word_t (hdr_item_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata (front_item),
        .pop   (!out_full),
        .empty (mid_empty),
        .rdata (mid_item)
    );

    fhcr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (!mid_empty),
        .item       (mid_item),
        .advance    (!out_full),
        .result     (back_result)
    );

    fhcr_queue #(
        .word_t (result_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (!mid_empty),
        .full  (out_full),
        .wdata (back_result),
        .pop   (pop),
        .empty (empty),
        .rdata (out_result)
    );

    assign packet_kind     = out_result.kind;
    assign accepted        = out_result.accepted;
    assign write_offset    = out_result.write_offset;
    assign message_done    = out_result.message_done;
    assign dropped_partial = out_result.dropped_partial;
    assign buffer_started  = out_result.buffer_started;

endmodule

>>> tb/sv/fragment_header_check_reassembly_tb.sv
// Self-checking testbench for fragment_header_check_reassembly: queue-style
// header and result ports, cfg writes of max_single_message between phases.
// Depends on fhcr_pkg and the RTL of the block; nothing else.
module fragment_header_check_reassembly_tb;

    import fhcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam longint unsigned MSG_LIMIT = MAX_MESSAGE_BYTES_DEF;
    localparam longint unsigned CHUNK_LIMIT = MAX_CHUNK_BYTES_DEF;

    typedef struct packed {
        logic [FIELD_W-1:0] session_id;
        logic [FIELD_W-1:0] message_size;
        logic [FIELD_W-1:0] chunk_offset;
        logic [FIELD_W-1:0] chunk_size;
        logic [FIELD_W-1:0] packet_length;
    } header_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [FIELD_W-1:0]  session_id = '0;
    logic [FIELD_W-1:0]  message_size = '0;
    logic [FIELD_W-1:0]  chunk_offset = '0;
    logic [FIELD_W-1:0]  chunk_size = '0;
    logic [FIELD_W-1:0]  packet_length = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [KIND_W-1:0]   packet_kind;
    logic                accepted;
    logic [OFFSET_W-1:0] write_offset;
    logic                message_done;
    logic                dropped_partial;
    logic                buffer_started;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [FIELD_W-1:0]  cfg_data = '0;

    header_t           header_queue[$];
    result_t           pending_results[$];
    header_t           cur_hdr;

    logic [FIELD_W-1:0] single_limit;
    logic               buf_valid;
    logic [FIELD_W-1:0] buf_session;
    logic [FIELD_W-1:0] buf_total;
    logic [FIELD_W-1:0] buf_count;
    longint unsigned    cur_max_single;

    bit          no_idle = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_left = 0;
    int          stall_cycles = 0;
    int          errors = 0;
    int          queued_total = 0;
    int          headers_sent = 0;
    int          results_seen = 0;
    int          cfg_writes = 0;
    int          done_seen = 0;
    int          drops_seen = 0;
    int          kind_seen[0:4];

    fragment_header_check_reassembly DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .session_id      (session_id),
        .message_size    (message_size),
        .chunk_offset    (chunk_offset),
        .chunk_size      (chunk_size),
        .packet_length   (packet_length),
        .empty           (empty),
        .pop             (pop),
        .packet_kind     (packet_kind),
        .accepted        (accepted),
        .write_offset    (write_offset),
        .message_done    (message_done),
        .dropped_partial (dropped_partial),
        .buffer_started  (buffer_started),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_session();
        buf_valid   = 1'b0;
        buf_session = '0;
        buf_total   = '0;
        buf_count   = '0;
    endfunction

    function automatic result_t predict_result(input header_t h);
        result_t     r;
        logic [32:0] span;
        logic        hdr_ok;
        r = '0;
        span = {1'b0, h.chunk_offset} + {1'b0, h.chunk_size};
        hdr_ok = (h.packet_length >= HEADER_BYTES_DEF)
              && (h.packet_length <= MAX_PACKET_BYTES_DEF)
              && (h.chunk_size <= MAX_CHUNK_BYTES_DEF)
              && ({1'b0, h.chunk_size} + 33'(HEADER_BYTES_DEF) == {1'b0, h.packet_length})
              && (h.message_size <= MAX_MESSAGE_BYTES_DEF)
              && (h.chunk_offset <= h.message_size)
              && (h.chunk_size <= h.message_size)
              && (span <= {1'b0, h.message_size});
        if (!hdr_ok) begin
            r.kind = KIND_INVALID;
        end
        else if (h.message_size <= single_limit) begin
            r.kind = KIND_SINGLE;
            if (h.chunk_offset == '0) begin
                r.accepted     = 1'b1;
                r.message_done = (h.chunk_size == h.message_size);
            end
        end
        else begin
            if (h.chunk_offset == '0)
                r.kind = KIND_NEW;
            else if (span == {1'b0, h.message_size})
                r.kind = KIND_END;
            else
                r.kind = KIND_CONTINUE;
            if (buf_session != h.session_id) begin
                r.dropped_partial = buf_valid;
                clear_session();
            end
            if (!buf_valid) begin
                if (h.chunk_offset == '0) begin
                    r.accepted       = 1'b1;
                    r.buffer_started = 1'b1;
                    buf_valid        = 1'b1;
                    buf_session      = h.session_id;
                    buf_total        = h.message_size;
                    buf_count        = h.chunk_size;
                end
            end
            else if (buf_total == h.message_size && buf_count == h.chunk_offset) begin
                r.accepted = 1'b1;
                buf_count  = span[FIELD_W-1:0];
            end
            if (r.accepted) begin
                r.write_offset = h.chunk_offset[OFFSET_W-1:0];
                if (buf_count == buf_total) begin
                    r.message_done = 1'b1;
                    clear_session();
                end
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("MISMATCH: %s", msg);
    endtask

    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
            return;
        end
        want = pending_results.pop_front();
        if (packet_kind !== want.kind)
            report_mismatch($sformatf("result %0d: packet_kind %0d, expected %0d",
                                      results_seen, packet_kind, want.kind));
        if (accepted !== want.accepted)
            report_mismatch($sformatf("result %0d: accepted %0b, expected %0b",
                                      results_seen, accepted, want.accepted));
        if (write_offset !== want.write_offset)
            report_mismatch($sformatf("result %0d: write_offset %0d, expected %0d",
                                      results_seen, write_offset, want.write_offset));
        if (message_done !== want.message_done)
            report_mismatch($sformatf("result %0d: message_done %0b, expected %0b",
                                      results_seen, message_done, want.message_done));
        if (dropped_partial !== want.dropped_partial)
            report_mismatch($sformatf("result %0d: dropped_partial %0b, expected %0b",
                                      results_seen, dropped_partial, want.dropped_partial));
        if (buffer_started !== want.buffer_started)
            report_mismatch($sformatf("result %0d: buffer_started %0b, expected %0b",
                                      results_seen, buffer_started, want.buffer_started));
        if (want.kind <= KIND_END)
            kind_seen[want.kind]++;
        if (want.message_done)
            done_seen++;
        if (want.dropped_partial)
            drops_seen++;
    endtask

    // send side: offer the next word, hold it while full, then idle for its gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            push     <= 1'b0;
            send_gap = 0;
        end
        else begin
            if (push && !full) begin
                pending_results.push_back(predict_result(cur_hdr));
                headers_sent++;
            end
            if (push && full) begin
                push <= 1'b1;
            end
            else if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end
            else if (header_queue.size() > 0) begin
                cur_hdr       = header_queue.pop_front();
                session_id    <= cur_hdr.session_id;
                message_size  <= cur_hdr.message_size;
                chunk_offset  <= cur_hdr.chunk_offset;
                chunk_size    <= cur_hdr.chunk_size;
                packet_length <= cur_hdr.packet_length;
                push          <= 1'b1;
                send_gap      = pick_gap();
            end
            else begin
                push <= 1'b0;
            end
        end
    end

    // receive side: check each popped word, stall at random, hold off twice
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pop       <= 1'b0;
            recv_gap  = 0;
            hold_left = 0;
        end
        else begin
            if (pop && !empty) begin
                check_result();
                results_seen++;
                recv_gap = pick_gap();
                if (results_seen == 40 || results_seen == 600)
                    hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (recv_gap > 0) begin
                recv_gap--;
                pop <= 1'b0;
            end
            else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("fragment_header_check_reassembly test failed");
        $finish;
    end

    task automatic add_header(input logic [31:0] sid, input logic [31:0] msize,
                              input logic [31:0] off, input logic [31:0] csize,
                              input logic [31:0] plen);
        header_queue.push_back('{sid, msize, off, csize, plen});
        queued_total++;
    endtask

    task automatic add_fragment(input logic [31:0] sid, input longint unsigned msize,
                                input longint unsigned off, input longint unsigned csize);
        add_header(sid, msize[31:0], off[31:0], csize[31:0], csize[31:0] + 32'd64);
    endtask

    function automatic logic [31:0] pick_session();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 5)
            return $urandom_range(1, 4);
        return $urandom;
    endfunction

    function automatic longint unsigned pick_multi_size();
        longint unsigned lo;
        longint unsigned room;
        int              r;
        lo = cur_max_single + 1;
        if (lo > MSG_LIMIT)
            return $urandom_range(0, 70000);
        room = MSG_LIMIT - lo;
        r = $urandom_range(0, 99);
        if (r < 2)
            return MSG_LIMIT;
        if (r < 10)
            return lo + $urandom_range(0, (room < 300000) ? room : 300000);
        return lo + $urandom_range(0, (room < 4000) ? room : 4000);
    endfunction

    task automatic add_noise();
        longint unsigned msize;
        longint unsigned off;
        longint unsigned room;
        if ($urandom_range(0, 1)) begin
            add_header($urandom, $urandom, $urandom, $urandom, $urandom);
        end
        else begin
            msize = $urandom_range(0, MSG_LIMIT);
            off   = $urandom_range(0, msize);
            room  = msize - off;
            add_fragment(pick_session(), msize, off,
                         $urandom_range(0, (room < CHUNK_LIMIT) ? room : CHUNK_LIMIT));
        end
    endtask

    task automatic add_single();
        longint unsigned msize;
        longint unsigned off;
        longint unsigned room;
        msize = $urandom_range(0, (cur_max_single < 70000) ? cur_max_single : 70000);
        off   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, msize) : 0;
        room  = msize - off;
        if ($urandom_range(0, 1))
            add_fragment(pick_session(), msize, off, (room < CHUNK_LIMIT) ? room : CHUNK_LIMIT);
        else
            add_fragment(pick_session(), msize, off,
                         $urandom_range(0, (room < CHUNK_LIMIT) ? room : CHUNK_LIMIT));
    endtask

    // well-formed fragment train, with the odd drop, duplicate or intruder
    task automatic queue_message(input logic [31:0] sid, input longint unsigned msize);
        longint unsigned off;
        longint unsigned csize;
        longint unsigned cap;
        int              r;
        cap = (msize > 20000) ? $urandom_range(20000, CHUNK_LIMIT) : $urandom_range(1, msize / 2 + 1);
        off = 0;
        while (off < msize) begin
            csize = ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, cap);
            if (csize > msize - off)
                csize = msize - off;
            r = $urandom_range(0, 99);
            if (r >= 2) begin
                if (r < 4)
                    add_fragment(sid, msize + 1, off, csize);
                else if (r < 6)
                    add_noise();
                else if (r < 8)
                    add_fragment(pick_session(), msize, off, csize);
                else if (r < 10)
                    add_header(sid, msize[31:0], off[31:0], csize[31:0], csize[31:0] + 32'd65);
                add_fragment(sid, msize, off, csize);
                if (r >= 10 && r < 12)
                    add_fragment(sid, msize, off, csize);
            end
            off += csize;
        end
    endtask

    task automatic queue_random_phase(input int target);
        int start;
        int r;
        start = queued_total;
        while (queued_total - start < target) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                queue_message(pick_session(), pick_multi_size());
            else if (r < 85)
                add_single();
            else
                add_noise();
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (header_queue.size() != 0 || push || pending_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_max_single(input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        single_limit   = value;
        cur_max_single = value;
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        for (int k = 0; k <= 4; k++)
            kind_seen[k] = 0;
        single_limit   = MAX_SINGLE_RESET;
        cur_max_single = MAX_SINGLE_RESET;
        clear_session();

        // header limits, offset and size checks
        add_header(1, 100, 0, 0, 63);
        add_header(1, 100, 0, 65473, 65537);
        add_header(1, 100, 0, 10, 75);
        add_header(1, 4194305, 0, 100, 164);
        add_header(1, 100, 101, 0, 64);
        add_header(1, 100, 0, 101, 165);
        add_header(1, 100, 60, 50, 114);
        // single packets: empty, largest, partial, nonzero offset
        add_header(2, 0, 0, 0, 64);
        add_header(2, 65472, 0, 65472, 65536);
        add_header(2, 200, 0, 100, 164);
        add_header(2, 200, 100, 100, 164);
        // session zero with nothing buffered
        add_header(0, 70000, 100, 100, 164);
        // new, wrong offset, wrong size, end
        add_header(5, 65473, 0, 65472, 65536);
        add_header(5, 65473, 65471, 1, 65);
        add_header(5, 65474, 65472, 1, 65);
        add_header(5, 65473, 65472, 1, 65);
        // zero-length opener, then a second opener of the same session
        add_header(7, 100000, 0, 0, 64);
        add_header(7, 100000, 0, 1000, 1064);
        // another session drops the partial and is rejected
        add_header(9, 100000, 1000, 1000, 1064);
        // largest message, then an intruder at the far end
        add_header(9, 4194304, 0, 65472, 65536);
        add_header(9, 4194304, 65472, 65472, 65536);
        add_header(0, 4194304, 4194304, 0, 64);
        add_header(3, 4194304, 0, 65472, 65536);
        add_header(32'hFFFF_FFFF, 65500, 0, 65472, 65536);
        add_header(32'hFFFF_FFFF, 65500, 65472, 28, 92);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait_idle();
        write_max_single(32'd0);
        queue_random_phase(300);

        wait_idle();
        write_max_single(32'd300);
        no_idle = 1'b1;
        queue_random_phase(350);

        wait_idle();
        no_idle = 1'b0;
        write_max_single(32'hFFFF_FFFF);
        queue_random_phase(150);

        wait_idle();
        write_max_single(32'd70000);
        queue_random_phase(300);

        wait_idle();
        write_max_single(MAX_SINGLE_RESET);
        queue_random_phase(150);

        wait_idle();
        repeat (8) @(negedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));

        $display("covered %0d headers over %0d cfg settings: %0d invalid, %0d single, %0d new",
                 headers_sent, cfg_writes + 1, kind_seen[KIND_INVALID], kind_seen[KIND_SINGLE],
                 kind_seen[KIND_NEW]);
        $display("%0d continue, %0d end, %0d messages completed, %0d partials dropped",
                 kind_seen[KIND_CONTINUE], kind_seen[KIND_END], done_seen, drops_seen);
        if (errors == 0)
            $display("fragment_header_check_reassembly test passed");
        else
            $display("fragment_header_check_reassembly test failed");
        $finish;
    end

endmodule

>>> files.f
src/fhcr_pkg.sv
src/fhcr_queue.sv
src/fhcr_front.sv
src/fhcr_back.sv
src/fragment_header_check_reassembly.sv
tb/sv/fragment_header_check_reassembly_tb.sv
